// ===== hdl/scc_pkg.sv =====
// Shared types and codes of the sensor calibration capture block.
// No dependencies; imported by the core.
package scc_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [6:0] DZ_AT_FLEX  = 7'd10;
  localparam logic [7:0] FWD_X_RESET = 8'd127;

  typedef enum logic [2:0] {
    MODE_BUTTON  = 3'd0,
    MODE_FLEX    = 3'd1,
    MODE_STICK   = 3'd2,
    MODE_TRIGGER = 3'd3,
    MODE_START   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_FLEX     = 3'd1,
    STEP_CENTER   = 3'd2,
    STEP_RANGE    = 3'd3,
    STEP_DEADZONE = 3'd4,
    STEP_FORWARD  = 3'd5,
    STEP_TRIGGER  = 3'd6
  } step_t;

  typedef enum logic [1:0] {
    REC_STATUS = 2'd0,
    REC_FLEX   = 2'd1,
    REC_STICK  = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_CENTER   = 2'd1,
    REG_TRIG_MIN = 2'd2,
    REG_TRIG_MAX = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWB,
    ST_STATUS,
    ST_CRD,
    ST_CEMIT,
    ST_STICK
  } state_t;

endpackage

// ===== hdl/scc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read. No dependencies.
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sensor_calibration_capture_core.sv =====
// Sensor calibration capture core: step sequencer, flex min/max RAM, stick
// and trigger measurement, commit record stream. Uses scc_pkg and scc_ram.
//
// A user of this block: each input word yields one status word, except the
// button edge that leaves the trigger step (or the flex step on the short
// path), which yields SENSORS flex records and a final stick/trigger record
// with tlast. A non-flex word is accepted, then its status word is loaded;
// a flex sample has its min/max pair read from the flex RAM on accept,
// then updated and written back (ST_FWB) before the status word. A commit is
// accepted, reads the first entry (ST_CRD), then emits one record a cycle
// from the RAM read port while the output is not stalled, then the stick record.
// The flex RAM needs no clearing pass; per-entry valid bits stand in for
// its start values. The config channel is always ready.
module sensor_calibration_capture_core
  import scc_pkg::*;
#(
  parameter int SENSORS   = 16,
  parameter int FLEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // button_level, full_path, sensor_index[3:0], flex_value[15:0],
  // stick_x[7:0], stick_y[7:0], trigger_value[7:0], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode[2:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // step[2:0], record_sensor[3:0], cal_min[15:0], cal_max[15:0],
  // center_x, center_y, stick_range, forward_x, forward_y (8 each),
  // deadzone_pct[6:0], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // record_kind[1:0]
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int FB = FLEX_BITS;
  localparam logic [16:0] FLEX_TOP = 17'((64'd1 << FLEX_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SENSORS - 1);
  localparam logic [5:0] SENS_CNT = 6'(SENSORS);

  // input fields
  logic [2:0]  in_mode;
  logic        in_btn, in_full;
  logic [3:0]  in_idx;
  logic [15:0] in_flex;
  logic [7:0]  in_sx, in_sy, in_tv;

  assign in_mode = s_tuser[2:0];
  assign in_btn  = s_tdata[0];
  assign in_full = s_tdata[1];
  assign in_idx  = s_tdata[5:2];
  assign in_flex = s_tdata[21:6];
  assign in_sx   = s_tdata[29:22];
  assign in_sy   = s_tdata[37:30];
  assign in_tv   = s_tdata[45:38];

  state_t state, state_next;
  step_t  cur_step;
  logic   full_flag, btn_prev, commit_full;

  logic [6:0] dflt_dz;
  logic [7:0] dflt_center, dflt_tmin, dflt_tmax;

  logic [7:0] meas_x, meas_y, center_x, center_y;
  logic [7:0] dir_up, dir_down, dir_left, dir_right;
  logic [7:0] range_work;
  logic [6:0] dz_work;
  logic signed [7:0] best_x, best_y, fwd_x, fwd_y;
  logic [15:0] best_mag;
  logic [7:0] trig_lo, trig_hi;

  logic [SENSORS-1:0] flex_vld;
  logic [AW-1:0]      fl_addr, cnt;
  logic [FB-1:0]      fl_val;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [2*FB-1:0] ram_wdata, ram_rdata;

  logic acc, slot_free, out_load, btn_edge, flex_go, do_commit, enter_en;
  step_t enter_step;

  assign acc       = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign btn_edge  = in_btn && !btn_prev;
  assign flex_go   = (in_mode == MODE_FLEX) && (cur_step == STEP_FLEX) &&
                     ({2'b00, in_idx} < SENS_CNT);

  // step sequencing on the accepted word
  always_comb begin
    enter_en   = 1'b0;
    enter_step = STEP_IDLE;
    do_commit  = 1'b0;
    if (in_mode == MODE_START) begin
      enter_en   = 1'b1;
      enter_step = STEP_FLEX;
    end else if (in_mode == MODE_BUTTON && btn_edge) begin
      unique case (cur_step)
        STEP_FLEX: begin
          if (full_flag) begin
            enter_en   = 1'b1;
            enter_step = STEP_CENTER;
          end else begin
            do_commit = 1'b1;
          end
        end
        STEP_CENTER: begin
          enter_en   = 1'b1;
          enter_step = STEP_RANGE;
        end
        STEP_RANGE: begin
          enter_en   = 1'b1;
          enter_step = STEP_DEADZONE;
        end
        STEP_DEADZONE: begin
          enter_en   = 1'b1;
          enter_step = STEP_FORWARD;
        end
        STEP_FORWARD: begin
          enter_en   = 1'b1;
          enter_step = STEP_TRIGGER;
        end
        STEP_TRIGGER: do_commit = 1'b1;
        default: ;
      endcase
    end
  end

  // stick deviation math
  logic signed [7:0]  dx, dy;
  logic [7:0]         neg_dx, neg_dy, min_ab, min_cd, min_rng;
  logic signed [15:0] sq_x, sq_y;
  logic [15:0]        mag;

  always_comb begin
    dx      = signed'(in_sx - center_x);
    dy      = signed'(in_sy - center_y);
    neg_dx  = 8'(-dx);
    neg_dy  = 8'(-dy);
    sq_x    = dx * dx;
    sq_y    = dy * dy;
    mag     = unsigned'(sq_x) + unsigned'(sq_y);
    min_ab  = (dir_down < dir_up) ? dir_down : dir_up;
    min_cd  = (dir_right < dir_left) ? dir_right : dir_left;
    min_rng = (min_cd < min_ab) ? min_cd : min_ab;
  end

  // flex write-back
  logic [FB-1:0] old_lo, old_hi, new_lo, new_hi, sat_val;

  always_comb begin
    sat_val = ({1'b0, in_flex} > FLEX_TOP) ? '1 : in_flex[FB-1:0];
    old_lo  = flex_vld[fl_addr] ? ram_rdata[FB-1:0] : '1;
    old_hi  = flex_vld[fl_addr] ? ram_rdata[2*FB-1:FB] : '0;
    new_lo  = (fl_val < old_lo) ? fl_val : old_lo;
    new_hi  = (fl_val > old_hi) ? fl_val : old_hi;
    ram_wdata = {new_hi, new_lo};
  end

  scc_ram #(
    .WIDTH(2 * FB),
    .DEPTH(SENSORS)
  ) u_flex_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fl_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (flex_go) begin
            state_next = ST_FWB;
          end else if (do_commit) begin
            state_next = ST_CRD;
          end else begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_FWB:    state_next = ST_STATUS;
      ST_STATUS: if (slot_free) state_next = ST_IDLE;
      ST_CRD:    state_next = ST_CEMIT;
      ST_CEMIT:  if (slot_free && cnt == LAST_ADDR) state_next = ST_STICK;
      ST_STICK:  if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_we    = (state == ST_FWB);
    ram_re    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (acc && flex_go) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(in_idx);
        end
      end
      ST_CRD: ram_re = 1'b1;
      ST_CEMIT: begin
        out_load = slot_free;
        if (slot_free && cnt != LAST_ADDR) begin
          ram_re    = 1'b1;
          ram_raddr = cnt + 1'b1;
        end
      end
      ST_STATUS, ST_STICK: out_load = slot_free;
      default: ;
    endcase
  end

  // record assembly
  logic [OUT_DATA_W-1:0] rec_data;
  rec_kind_t             rec_kind;
  logic                  rec_last;
  logic [15:0]           rmin, rmax;

  always_comb begin
    rec_data = '0;
    rec_kind = REC_STATUS;
    rec_last = 1'b1;
    rmin     = '0;
    rmax     = '0;
    priority case (state)
      ST_CEMIT: begin
        rec_kind = REC_FLEX;
        rec_last = 1'b0;
        rmin = flex_vld[cnt] ? 16'(ram_rdata[FB-1:0]) : FLEX_TOP[15:0];
        rmax = flex_vld[cnt] ? 16'(ram_rdata[2*FB-1:FB]) : 16'd0;
        rec_data = {2'b00, 7'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, rmax, rmin,
                    4'(cnt), 3'(STEP_IDLE)};
      end
      ST_STICK: begin
        rec_kind = REC_STICK;
        rmin = 16'(commit_full ? trig_lo : dflt_tmin);
        rmax = 16'(commit_full ? trig_hi : dflt_tmax);
        rec_data = {2'b00, dz_work, fwd_y, fwd_x, range_work, center_y, center_x,
                    rmax, rmin, 4'd0, 3'(STEP_IDLE)};
      end
      default: begin
        rec_data = {85'd0, 3'(cur_step)};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_step    <= STEP_IDLE;
      full_flag   <= 1'b1;
      btn_prev    <= 1'b0;
      flex_vld    <= '0;
      m_tvalid    <= 1'b0;
      dflt_dz     <= 7'd10;
      dflt_center <= 8'd127;
      dflt_tmin   <= 8'd80;
      dflt_tmax   <= 8'd110;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEADZONE: dflt_dz     <= cfg_data[6:0];
          REG_CENTER:   dflt_center <= cfg_data;
          REG_TRIG_MIN: dflt_tmin   <= cfg_data;
          REG_TRIG_MAX: dflt_tmax   <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (ram_we) begin
        flex_vld[fl_addr] <= 1'b1;
      end

      if (acc) begin
        if (in_mode == MODE_BUTTON) begin
          btn_prev <= in_btn;
        end
        if (in_mode == MODE_START) begin
          full_flag <= in_full;
        end
        if (do_commit) begin
          cur_step <= STEP_IDLE;
        end else if (enter_en) begin
          cur_step <= enter_step;
          if (enter_step == STEP_FLEX) begin
            flex_vld <= '0;
          end
        end
      end
    end
  end

  // payload and measurement registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rec_data;
      m_tuser <= rec_kind;
      m_tlast <= rec_last;
    end

    if (state == ST_CRD) begin
      cnt <= '0;
    end else if (state == ST_CEMIT && slot_free && cnt != LAST_ADDR) begin
      cnt <= cnt + 1'b1;
    end

    if (acc) begin
      fl_addr <= AW'(in_idx);
      fl_val  <= sat_val;
      if (do_commit) begin
        commit_full <= (cur_step == STEP_TRIGGER);
      end

      if (enter_en) begin
        unique case (enter_step)
          STEP_FLEX: begin
            center_x   <= dflt_center;
            center_y   <= dflt_center;
            range_work <= dflt_center;
            fwd_x      <= signed'(FWD_X_RESET);
            fwd_y      <= '0;
            dz_work    <= DZ_AT_FLEX;
          end
          STEP_CENTER: begin
            meas_x <= '0;
            meas_y <= '0;
          end
          STEP_RANGE: begin
            center_x  <= meas_x;
            center_y  <= meas_y;
            dir_up    <= '0;
            dir_down  <= '0;
            dir_left  <= '0;
            dir_right <= '0;
          end
          STEP_DEADZONE: begin
            range_work <= min_rng;
            dz_work    <= dflt_dz;
          end
          STEP_FORWARD: begin
            best_x   <= '0;
            best_y   <= '0;
            best_mag <= '0;
          end
          STEP_TRIGGER: begin
            fwd_x   <= best_x;
            fwd_y   <= best_y;
            trig_lo <= 8'hFF;
            trig_hi <= 8'h00;
          end
          default: ;
        endcase
      end

      if (in_mode == MODE_STICK) begin
        priority case (cur_step)
          STEP_CENTER: begin
            meas_x <= in_sx;
            meas_y <= in_sy;
          end
          STEP_RANGE: begin
            if (dx > 0) begin
              if (dx > signed'({1'b0, dir_right[6:0]}) || dir_right[7] == 1'b0 &&
                  8'(dx) > dir_right) dir_right <= 8'(dx);
            end else if (neg_dx > dir_left) begin
              dir_left <= neg_dx;
            end
            if (dy > 0) begin
              if (8'(dy) > dir_up) dir_up <= 8'(dy);
            end else if (neg_dy > dir_down) begin
              dir_down <= neg_dy;
            end
          end
          STEP_FORWARD: begin
            if (mag > best_mag) begin
              best_x   <= dx;
              best_y   <= dy;
              best_mag <= mag;
            end
          end
          default: ;
        endcase
      end

      if (in_mode == MODE_TRIGGER && cur_step == STEP_TRIGGER) begin
        if (in_tv < trig_lo) trig_lo <= in_tv;
        if (in_tv > trig_hi) trig_hi <= in_tv;
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous word still in work");

  a_flex_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REC_FLEX |-> !m_tlast)
    else $error("flex record marked last");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_CEMIT || state == ST_CRD || state == ST_STICK |-> cur_step == STEP_IDLE)
    else $error("commit running outside idle step");

  a_stick_after_sweep: assert property (@(posedge clk) disable iff (rst)
    state == ST_STICK |-> cnt == LAST_ADDR)
    else $error("stick record before all flex records");

endmodule
